// ===== design/qte_pkg.sv =====
// Shared types, constants and helper functions for the quaternion to Euler angle pipeline.
// No dependencies. Imported by qte_cordic, qte_isqrt and quaternion_to_euler_angles.
`default_nettype none
package qte_pkg;

  localparam int OPW  = 35;  // CORDIC operand width (signed)
  localparam int ANGW = 36;  // internal angle width, 30 fraction bits

  localparam logic signed [ANGW-1:0] ANG_PI     = 36'sd3373259426;
  localparam logic signed [37:0]     ANG_PI_W   = 38'sd3373259426;
  localparam logic signed [37:0]     ANG_2PI_W  = 38'sd6746518852;
  localparam logic signed [32:0]     TEST_LIMIT = 33'sd535797170;
  localparam logic signed [15:0]     OUT_PI      = 16'sd25736;
  localparam logic signed [15:0]     OUT_HALF_PI = 16'sd12868;
  localparam int MAX_STEPS = 24;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    pole_t                  pole;
    logic signed [OPW-1:0]  hy;
    logic signed [OPW-1:0]  hx;
    logic signed [OPW-1:0]  by;
    logic signed [OPW-1:0]  bx;
    logic signed [33:0]     t;
  } side_t;

  // atan(2^-i), 30 fraction bits
  function automatic logic [29:0] atan_entry(input int unsigned i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314857;
      1: v = 30'd497837829;
      2: v = 30'd263043837;
      3: v = 30'd133525159;
      4: v = 30'd67021687;
      5: v = 30'd33543516;
      6: v = 30'd16775851;
      7: v = 30'd8388437;
      8: v = 30'd4194283;
      9: v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // 30 -> 13 fraction bits, round half up, symmetric saturation
  function automatic logic signed [15:0] to_q13(input logic signed [37:0] a,
                                                input logic signed [15:0] lim);
    logic signed [37:0] r;
    logic signed [37:0] l;
    r = (a + 38'sd65536) >>> 17;
    l = 38'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/qte_isqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage (31 stages).
// Depends on qte_pkg (imported for house consistency of the pipeline).
`default_nettype none
module qte_isqrt
  import qte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        ce,
  input  wire logic [60:0] rad,
  output logic      [30:0] root
);

  localparam int NS = 31;

  logic [61:0] vs [NS+1];
  logic [61:0] rs [NS+1];

  assign vs[0] = {1'b0, rad};
  assign rs[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [61:0] BIT = 62'(1) << (2 * (NS - 1 - i));
    logic [61:0] trial;
    assign trial = rs[i] + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        if (vs[i] >= trial) begin
          vs[i+1] <= vs[i] - trial;
          rs[i+1] <= (rs[i] >> 1) + BIT;
        end else begin
          vs[i+1] <= vs[i];
          rs[i+1] <= rs[i] >> 1;
        end
      end
    end
  end

  assign root = rs[NS][30:0];

endmodule
`default_nettype wire

// ===== design/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2: one prep stage plus one stage per micro-rotation.
// Depends on qte_pkg for widths, pi and the arctangent table.
`default_nettype none
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   ce,
  input  wire logic signed [OPW-1:0]  yin,
  input  wire logic signed [OPW-1:0]  xin,
  output logic signed [ANGW-1:0]      angle
);

  localparam int XW = OPW + 3;

  logic signed [XW-1:0]   xs [STEPS+1];
  logic signed [XW-1:0]   ys [STEPS+1];
  logic signed [ANGW-1:0] zs [STEPS+1];
  logic                   zf [STEPS+1];

  // left half plane: flip the vector, start from +-pi
  always_ff @(posedge clk) begin
    if (ce) begin
      zf[0] <= (xin == '0) && (yin == '0);
      if (xin < 0) begin
        xs[0] <= -XW'(xin);
        ys[0] <= -XW'(yin);
        zs[0] <= (yin >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        xs[0] <= XW'(xin);
        ys[0] <= XW'(yin);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ANGW-1:0] ATAN_I = ANGW'(atan_entry(i));
    always_ff @(posedge clk) begin
      if (ce) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_I;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_I;
        end
      end
    end
  end

  assign angle = zf[STEPS] ? '0 : zs[STEPS];

endmodule
`default_nettype wire

// ===== design/quaternion_to_euler_angles.sv =====
// Top level: unit quaternion (Q1.15) to bank/heading/attitude (Q3.13) with pole detection.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | quat_x, quat_y, quat_z, quat_w (64 bits)    | -
//  m_*     | out | bank_angle, heading_angle, attitude_angle,  | pole_case
//          |     | zero pad to 48 bits                         |
//
// One transaction per cycle sustained while m_tready is high; the pipeline is 4 front stages,
// a 31-stage square root, CORDIC prep + one stage per step, and an output reg.
// The whole pipeline advances together; it holds when m_tvalid is high and m_tready low.
// rst clears only the valid bits; no state survives between transactions.
`default_nettype none
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // bank_angle, heading_angle, attitude_angle, pad
  output logic [1:0]       m_tuser    // pole_case
);

  localparam int STEPS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int SQ     = 31;
  localparam int SIDE_D = SQ + 2;
  localparam int LAT    = 6 + SQ + STEPS;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[LAT-1];

  // stage 1: products
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qz = s_tdata[47:32];
  assign qw = s_tdata[63:48];

  logic signed [31:0] pxy, pzw, pxx, pyy, pzz, pxw, pyz, pyw, pxz;
  logic signed [15:0] x1, w1;
  always_ff @(posedge clk) begin
    if (ce) begin
      pxy <= qx * qy;
      pzw <= qz * qw;
      pxx <= qx * qx;
      pyy <= qy * qy;
      pzz <= qz * qz;
      pxw <= qx * qw;
      pyz <= qy * qz;
      pyw <= qy * qw;
      pxz <= qx * qz;
      x1  <= qx;
      w1  <= qw;
    end
  end

  // stage 2: discriminant, operand sums
  logic signed [32:0] test;
  logic signed [33:0] t2, ta;
  logic [30:0]        u_c;
  side_t              side_c;
  assign test = 33'(pxy) + 33'(pzw);
  assign t2   = {test, 1'b0};
  assign ta   = (t2 < 0) ? -t2 : t2;
  assign u_c  = (ta > 34'sd1073741824) ? 31'd1073741824 : ta[30:0];

  always_comb begin
    side_c.t  = t2;
    side_c.by = 35'sd2 * (35'(pxw) - 35'(pyz));
    side_c.bx = 35'sd1073741824 - 35'sd2 * (35'(pxx) + 35'(pzz));
    if (test > TEST_LIMIT) begin
      side_c.pole = POLE_NORTH;
      side_c.hy   = OPW'(x1);
      side_c.hx   = OPW'(w1);
    end else if (test < -TEST_LIMIT) begin
      side_c.pole = POLE_SOUTH;
      side_c.hy   = OPW'(x1);
      side_c.hx   = OPW'(w1);
    end else begin
      side_c.pole = POLE_NONE;
      side_c.hy   = 35'sd2 * (35'(pyw) - 35'(pxz));
      side_c.hx   = 35'sd1073741824 - 35'sd2 * (35'(pyy) + 35'(pzz));
    end
  end

  side_t       side2;
  logic [30:0] u2;
  always_ff @(posedge clk) begin
    if (ce) begin
      side2 <= side_c;
      u2    <= u_c;
    end
  end

  // stages 3-4: 1 - t^2
  logic [61:0] uu3;
  logic [60:0] rad4;
  always_ff @(posedge clk) begin
    if (ce) begin
      uu3  <= 62'(u2) * 62'(u2);
      rad4 <= 61'(62'h1000_0000_0000_0000 - uu3);
    end
  end

  logic [30:0] root;
  qte_isqrt u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .rad  (rad4),
    .root (root)
  );

  // side data rides alongside the square root
  side_t side_d [SIDE_D];
  always_ff @(posedge clk) begin
    if (ce) begin
      side_d[0] <= side2;
      for (int i = 1; i < SIDE_D; i++) side_d[i] <= side_d[i-1];
    end
  end

  side_t sd;
  assign sd = side_d[SIDE_D-1];

  logic signed [ANGW-1:0] h_ang, a_ang, b_ang;
  qte_cordic #(.STEPS(STEPS)) u_head (
    .clk(clk), .ce(ce), .yin(sd.hy), .xin(sd.hx), .angle(h_ang)
  );
  qte_cordic #(.STEPS(STEPS)) u_att (
    .clk(clk), .ce(ce), .yin(OPW'(sd.t)), .xin(OPW'({1'b0, root})), .angle(a_ang)
  );
  qte_cordic #(.STEPS(STEPS)) u_bank (
    .clk(clk), .ce(ce), .yin(sd.by), .xin(sd.bx), .angle(b_ang)
  );

  pole_t pole_d [STEPS+1];
  always_ff @(posedge clk) begin
    if (ce) begin
      pole_d[0] <= sd.pole;
      for (int i = 1; i <= STEPS; i++) pole_d[i] <= pole_d[i-1];
    end
  end

  // final: pole handling, wrap, rounding
  pole_t              pole_f;
  logic signed [37:0] hw;
  logic signed [15:0] bank_c, head_c, att_c;
  assign pole_f = pole_d[STEPS];

  always_comb begin
    hw     = 38'(h_ang);
    bank_c = '0;
    att_c  = to_q13(38'(a_ang), OUT_HALF_PI);
    case (pole_f)
      POLE_NORTH: begin
        hw    = 38'(h_ang) <<< 1;
        att_c = OUT_HALF_PI;
      end
      POLE_SOUTH: begin
        hw    = -(38'(h_ang) <<< 1);
        att_c = -OUT_HALF_PI;
      end
      default: begin
        bank_c = to_q13(38'(b_ang), OUT_PI);
      end
    endcase
    // only the doubled pole heading is wrapped; the regular one just saturates
    if (pole_f != POLE_NONE) begin
      if (hw > ANG_PI_W) hw = hw - ANG_2PI_W;
      if (hw < -ANG_PI_W) hw = hw + ANG_2PI_W;
    end
    head_c = to_q13(hw, OUT_PI);
  end

  logic signed [15:0] bank_q, head_q;
  logic signed [14:0] att_q;
  pole_t              pole_q;
  always_ff @(posedge clk) begin
    if (ce) begin
      bank_q <= bank_c;
      head_q <= head_c;
      att_q  <= att_c[14:0];
      pole_q <= pole_f;
    end
  end

  assign m_tdata = {1'b0, att_q, head_q, bank_q};
  assign m_tuser = pole_q;

  a_pole_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("invalid pole code");

  a_pole_outs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (pole_q == POLE_NORTH)) |-> (bank_q == 16'sd0 && att_q == 15'sd12868))
    else $error("north pole outputs wrong");

  a_att_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (att_q <= 15'sd12868 && att_q >= -15'sd12868))
    else $error("attitude out of range");

  a_rst_clear: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("valid after reset");

endmodule
`default_nettype wire

// ===== tb/tb_quaternion_to_euler_angles.sv =====
// Testbench for quaternion_to_euler_angles: drives quaternion transactions, predicts
// bank/heading/attitude/pole with an integer CORDIC model and checks every result in order.
// Depends on qte_pkg and the design sources.
`default_nettype none
module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 37 + STEPS;

  typedef struct {
    logic signed [15:0] bank;
    logic signed [15:0] head;
    logic signed [14:0] att;
    pole_t              pole;
  } angles_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  angles_t expected_angles[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint atan_rad(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint base, acc, xn, yn;
    int n;
    base = 0;
    acc = 0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      base = (yv >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < n; i++) begin
      if (yv >= 0) begin
        xn = xv + (yv >>> i);
        yn = yv - (xv >>> i);
        acc += atan_rad(i);
      end else begin
        xn = xv - (yv >>> i);
        yn = yv + (xv >>> i);
        acc -= atan_rad(i);
      end
      xv = xn;
      yv = yn;
    end
    return base + acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint wrap_angle(longint a);
    longint p;
    p = 64'sd3373259426;
    if (a > p) a -= 2 * p;
    if (a < -p) a += 2 * p;
    return a;
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    angles_t r;
    longint x, y, z, w, tst, t, c;
    longint unsigned u;
    x = longint'($signed(q[15:0]));
    y = longint'($signed(q[31:16]));
    z = longint'($signed(q[47:32]));
    w = longint'($signed(q[63:48]));
    tst = x * y + z * w;
    r.bank = '0;
    if (tst > 535797170) begin
      r.pole = POLE_NORTH;
      r.head = 16'(round_q13(wrap_angle(2 * vector_angle(x, w)), 25736));
      r.att = 15'(12868);
    end else if (tst < -535797170) begin
      r.pole = POLE_SOUTH;
      r.head = 16'(round_q13(wrap_angle(-2 * vector_angle(x, w)), 25736));
      r.att = -15'sd12868;
    end else begin
      r.pole = POLE_NONE;
      t = 2 * tst;
      u = longint'(t < 0 ? -t : t);
      if (u > 64'd1073741824) u = 64'd1073741824;
      c = int_sqrt((64'd1 << 60) - u * u);
      r.head = 16'(round_q13(vector_angle(2 * (y * w - x * z),
                                          1073741824 - 2 * (y * y + z * z)), 25736));
      r.att = 15'(round_q13(vector_angle(t, c), 12868));
      r.bank = 16'(round_q13(vector_angle(2 * (x * w - y * z),
                                          1073741824 - 2 * (x * x + z * z)), 25736));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // s_tvalid stays high between back-to-back transactions
  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w, z, y, x};
    expected_angles.insert(expected_angles.size(), euler_of({w, z, y, x}));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver stall, updated each edge
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    angles_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = expected_angles.pop_front();
        if ($signed(m_tdata[15:0]) != e.bank)
          report_mismatch("bank_angle", $signed(m_tdata[15:0]), e.bank);
        if ($signed(m_tdata[31:16]) != e.head)
          report_mismatch("heading_angle", $signed(m_tdata[31:16]), e.head);
        if ($signed(m_tdata[46:32]) != e.att)
          report_mismatch("attitude_angle", $signed(m_tdata[46:32]), e.att);
        if (m_tdata[47] != 1'b0) report_mismatch("pad bit", m_tdata[47], 0);
        if (m_tuser != e.pole) report_mismatch("pole_case", m_tuser, e.pole);
      end
    end
  end

  function automatic logic [15:0] q15(real v);
    return 16'($rtoi(v * 32767.0));
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);  // identity
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // all components zero
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // most negative, non-unit
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);  // largest, north pole
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);  // south pole
    send_quat(q15(0.7071), q15(0.7071), 16'h0000, 16'h0000);  // north, w zero
    send_quat(q15(0.7071), -q15(0.7071), 16'h0000, 16'h0000); // south
    send_quat(q15(0.5), q15(0.5), q15(0.5), q15(0.5));
    send_quat(-q15(0.5), q15(0.5), -q15(0.5), q15(0.5));
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);  // negative x operand
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_quat(q15(0.6), q15(0.4), q15(0.4), -q15(0.56));
    send_quat(16'd23147, 16'd23147, 16'd0, 16'd0);       // test just under threshold
    send_quat(16'd23148, 16'd23148, 16'd0, 16'd0);       // test just over threshold
    send_quat(16'd23147, -16'd23147, 16'd0, 16'd0);
    send_quat(16'd23148, -16'd23148, 16'd0, 16'd0);
    send_quat(-q15(0.7071), -q15(0.7071), 16'h0000, q15(0.01));
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
  endtask

  task automatic test_random(int count);
    real a, b, c, d, n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        a = real'($signed(16'($urandom)));
        b = real'($signed(16'($urandom)));
        c = real'($signed(16'($urandom)));
        d = real'($signed(16'($urandom)));
        if ($urandom_range(4) == 0) begin
          // bias toward the poles
          b = a * (($urandom_range(1)) ? 1.0 : -1.0);
          c = c / 16.0;
          d = d / 16.0;
        end
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(q15(a / n), q15(b / n), q15(c / n), q15(d / n));
      end
    end
  endtask

  task automatic test_idle_phases();
    int pct[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{14, 14}};
    foreach (pct[p]) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      test_random(280);
      if (p == 1) drain();  // sender holds off until every result is back
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    recv_stall_pct = 0;
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
